[hw/rtl/tpks_pkg.sv]
// shared types and constants of the tabulated phase kinetics step unit
package tpks_pkg;

  localparam int unsigned TablePointsDef = 11;
  localparam int unsigned DivDw = 49;
  localparam int unsigned DivVw = 34;
  localparam logic [16:0] FxOne = 17'h10000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CHECK,
    OP_DIV_RATIO,
    OP_RCMP,
    OP_EMUL,
    OP_EFF,
    OP_SEG,
    OP_LATCH_LO,
    OP_MUL1,
    OP_MUL2,
    OP_TIME,
    OP_SEARCH,
    OP_SHIFT,
    OP_DIV_Q,
    OP_QLAT,
    OP_NEWF,
    OP_MASS
  } dp_op_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_IDX,
    RD_IDX1
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    dp_op_e  op;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic invalid;
    logic direct;
    logic ratio_big;
    logic seg_past;
    logic hit;
    logic flat;
    logic last_seg;
    logic div_done;
  } dp_stat_t;

endpackage

[hw/rtl/tpks_if.sv]
// valid/ready channels for request and result beats

interface tpks_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_time;
  logic signed [31:0] time_step;
  logic signed [31:0] current_time;
  logic signed [17:0] incubation_fraction;
  logic signed [17:0] mass_fraction;

  modport source (
    output valid, req_type, entry_index, entry_time, time_step, current_time,
           incubation_fraction, mass_fraction,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_time, time_step, current_time,
           incubation_fraction, mass_fraction,
    output ready
  );
endinterface

interface tpks_out_if;
  logic        valid;
  logic        ready;
  logic        step_ok;
  logic [16:0] incubation_increment;
  logic [16:0] mass_increment;

  modport source (
    output valid, step_ok, incubation_increment, mass_increment,
    input  ready
  );
  modport sink (
    input  valid, step_ok, incubation_increment, mass_increment,
    output ready
  );
endinterface

[hw/rtl/tabulated_phase_kinetics_step_unit.sv]
// top level of the tabulated phase kinetics step unit
//
// in_i carries request beats. req_type 0 writes one table time (entry 0 is the
// incubation time, entry k the time at k/(TABLE_POINTS-1) transformed); an index
// past the table is dropped. A load beat gives no result.
// req_type 1 runs a kinetics step and gives exactly one result beat on
// out_o: step_ok and the incubation and mass increments in Q1.16.
// One item is worked on at a time: in_i.ready is high only while the unit is idle.
// A rejected step goes straight to its result. Any other step may run the serial
// divider twice (ratio and segment quotient) and walks the table one segment at
// a time; these set how long a step takes.
// The result stays in its output registers, valid high, until out_o.ready is seen;
// no new request is taken meanwhile.
// Reset clears the loaded flags, so steps report step_ok 0 until all entries are
// written again; table contents themselves are not cleared.
module tabulated_phase_kinetics_step_unit import tpks_pkg::*; #(
  parameter int unsigned TABLE_POINTS = TablePointsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpks_in_if.sink    in_i,
  tpks_out_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .req_type_i  (in_i.req_type),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tpks_dp #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .req_type_i             (in_i.req_type),
    .entry_index_i          (in_i.entry_index),
    .entry_time_i           (in_i.entry_time),
    .time_step_i            (in_i.time_step),
    .current_time_i         (in_i.current_time),
    .incubation_fraction_i  (in_i.incubation_fraction),
    .mass_fraction_i        (in_i.mass_fraction),
    .step_ok_o              (out_o.step_ok),
    .incubation_increment_o (out_o.incubation_increment),
    .mass_increment_o       (out_o.mass_increment)
  );

endmodule

[hw/rtl/tpks_div.sv]
// shared restoring divider, one quotient bit per cycle
module tpks_div import tpks_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivDw-1:0] dividend_i,
  input  logic [DivVw-1:0] divisor_i,
  output logic             done_o,
  output logic [DivDw-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivDw + 1);

  logic [DivDw-1:0] dvd_q;
  logic [DivVw-1:0] dvs_q;
  logic [DivVw-1:0] rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DivVw:0]   rem2;
  logic             take;

  assign rem2 = {rem_q, dvd_q[DivDw-1]};
  assign take = rem2 >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivDw);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as the dividend leaves at the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DivDw-2:0], take};
      rem_q <= take ? DivVw'(rem2 - {1'b0, dvs_q}) : DivVw'(rem2);
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

[hw/rtl/tpks_dp.sv]
// datapath: table store, operand registers, multiplier and divider
module tpks_dp import tpks_pkg::*; #(
  parameter int unsigned TABLE_POINTS = TablePointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic               req_type_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_time_i,
  input  logic signed [31:0] time_step_i,
  input  logic signed [31:0] current_time_i,
  input  logic signed [17:0] incubation_fraction_i,
  input  logic signed [17:0] mass_fraction_i,
  output logic               step_ok_o,
  output logic [16:0]        incubation_increment_o,
  output logic [16:0]        mass_increment_o
);

  localparam int unsigned Segs  = TABLE_POINTS - 1;
  localparam int unsigned IdxW  = $clog2(TABLE_POINTS);
  localparam int unsigned UW    = 17 + $clog2(TABLE_POINTS);
  localparam int unsigned SegIW = UW - 16;
  localparam int unsigned RcpSh = UW + $clog2(Segs);
  localparam int unsigned NfW   = 2 * UW + 1;
  localparam logic [63:0] RcpFull = ((64'd1 << RcpSh) + 64'(Segs) - 64'd1) / 64'(Segs);

  logic signed [31:0] tbl [TABLE_POINTS];
  logic signed [31:0] rd_q;
  logic [IdxW-1:0]    rd_addr;
  logic [TABLE_POINTS-1:0] loaded_q;

  logic signed [31:0] dt_q;
  logic               now_neg_q;
  logic signed [17:0] incu_q;
  logic signed [17:0] m_q;
  logic signed [31:0] t0_q;
  logic signed [33:0] step_q;
  logic signed [49:0] prod_q;
  logic signed [50:0] acc_q;
  logic signed [39:0] t_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;
  logic [IdxW-1:0]    idx_q;
  logic [16:0]        f_q;
  logic [16:0]        q_q;
  logic [16:0]        newf_q;
  logic               ok_q;
  logic [16:0]        incu_inc_q;
  logic [16:0]        mass_inc_q;

  logic [UW-1:0]      u_w;
  logic [SegIW-1:0]   i0_w;
  logic [16:0]        f_w;
  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [39:0] d_w;
  logic signed [32:0] den_w;
  logic               invalid_w;
  logic               direct_w;
  logic               hit_w;
  logic               last_w;
  logic               div_start;
  logic [DivDw-1:0]   div_dvd;
  logic [DivVw-1:0]   div_dvs;
  logic               div_done;
  logic [DivDw-1:0]   quot;
  logic               load_w;
  logic [UW-1:0]      nf_num_w;
  logic [NfW-1:0]     nf_prod_w;

  // table store
  assign load_w = cmd_i.accept && !req_type_i &&
                  ({2'b00, entry_index_i} < 6'(TABLE_POINTS));

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_IDX:  rd_addr = idx_q;
      RD_IDX1: rd_addr = idx_q + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      tbl[IdxW'(entry_index_i)] <= entry_time_i;
    end
    rd_q <= tbl[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (load_w) begin
      loaded_q[IdxW'(entry_index_i)] <= 1'b1;
    end
  end

  // mass fraction to segment and offset
  assign u_w  = UW'(m_q[16:0]) * UW'(Segs);
  assign i0_w = (u_w == '0) ? '0 : SegIW'((u_w - UW'(1)) >> 16);
  assign f_w  = 17'(u_w - {i0_w, 16'b0});

  always_comb begin
    case (cmd_i.op)
      OP_MUL1: begin
        mul_a = $signed({1'b0, f_q});
        mul_b = rd_q;
      end
      OP_MUL2: begin
        mul_a = $signed({1'b0, FxOne - f_q});
        mul_b = lo_q;
      end
      default: begin
        mul_a = $signed({1'b0, FxOne - incu_q[16:0]});
        mul_b = t0_q;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign d_w   = t_q - 40'(lo_q);
  assign den_w = 33'(hi_q) - 33'(lo_q);

  // fraction over the segment count by reciprocal multiply, exact for this range
  assign nf_num_w  = UW'({idx_q, 16'b0}) + UW'(q_q);
  assign nf_prod_w = NfW'(nf_num_w) * NfW'(RcpFull[UW:0]);

  assign invalid_w = (loaded_q != '1) || dt_q[31] || now_neg_q || incu_q[17] || m_q[17];
  assign direct_w  = (rd_q <= 32'sd0) || (incu_q >= $signed(18'h10000));
  assign hit_w     = (t_q >= 40'(lo_q)) && (t_q <= 40'(hi_q));
  assign last_w    = idx_q == IdxW'(Segs - 1);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd_i.op)
      OP_DIV_RATIO: begin
        div_start = 1'b1;
        div_dvd   = {2'b00, dt_q[30:0], 16'b0};
        div_dvs   = {2'b00, t0_q};
      end
      OP_DIV_Q: begin
        div_start = 1'b1;
        div_dvd   = {d_w[32:0], 16'b0};
        div_dvs   = {1'b0, den_w};
      end
      default: ;
    endcase
  end

  tpks_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && req_type_i) begin
      dt_q      <= time_step_i;
      now_neg_q <= current_time_i[31];
      incu_q    <= incubation_fraction_i;
      m_q       <= mass_fraction_i;
    end
    case (cmd_i.op)
      OP_CHECK: begin
        t0_q       <= rd_q;
        step_q     <= 34'(dt_q);
        ok_q       <= !invalid_w;
        mass_inc_q <= '0;
        incu_inc_q <= '0;
        if (!invalid_w && direct_w) begin
          incu_inc_q <= (incu_q >= $signed(18'h10000)) ? 17'd0 : FxOne;
        end
      end
      OP_RCMP: begin
        incu_inc_q <= quot[16:0];
      end
      OP_EMUL: begin
        prod_q <= mul_p;
      end
      OP_EFF: begin
        step_q     <= 34'(dt_q) - 34'(prod_q >>> 16);
        incu_inc_q <= FxOne - incu_q[16:0];
      end
      OP_SEG: begin
        idx_q  <= IdxW'(i0_w);
        f_q    <= f_w;
        newf_q <= FxOne;
      end
      OP_LATCH_LO: begin
        lo_q <= rd_q;
      end
      OP_MUL1: begin
        hi_q   <= rd_q;
        prod_q <= mul_p;
      end
      OP_MUL2: begin
        acc_q <= 51'(prod_q) + 51'(mul_p);
      end
      OP_TIME: begin
        t_q <= 40'(acc_q >>> 16) + 40'(step_q);
      end
      OP_SEARCH: begin
        q_q    <= '0;
        newf_q <= FxOne;
        if (!hit_w && !last_w) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      OP_SHIFT: begin
        lo_q <= hi_q;
        hi_q <= rd_q;
      end
      OP_QLAT: begin
        q_q <= quot[16:0];
      end
      OP_NEWF: begin
        newf_q <= 17'(nf_prod_w >> RcpSh);
      end
      OP_MASS: begin
        mass_inc_q <= ({1'b0, newf_q} > $unsigned(m_q)) ?
                      17'({1'b0, newf_q} - $unsigned(m_q)) : 17'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o           = '0;
    stat_o.invalid   = invalid_w;
    stat_o.direct    = direct_w;
    stat_o.ratio_big = (50'(quot) + 50'(incu_q[16:0])) > 50'(FxOne);
    stat_o.seg_past  = i0_w >= SegIW'(Segs);
    stat_o.hit       = hit_w;
    stat_o.flat      = hi_q == lo_q;
    stat_o.last_seg  = last_w;
    stat_o.div_done  = div_done;
  end

  assign step_ok_o              = ok_q;
  assign incubation_increment_o = incu_inc_q;
  assign mass_increment_o       = mass_inc_q;

endmodule

[hw/rtl/tpks_ctrl.sv]
// sequencer for load and step beats
module tpks_ctrl import tpks_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     req_type_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_T0    = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_RGO   = 5'd3;
  localparam logic [4:0] S_RWAIT = 5'd4;
  localparam logic [4:0] S_RCMP  = 5'd5;
  localparam logic [4:0] S_EMUL  = 5'd6;
  localparam logic [4:0] S_EFF   = 5'd7;
  localparam logic [4:0] S_SEG   = 5'd8;
  localparam logic [4:0] S_RLO   = 5'd9;
  localparam logic [4:0] S_LO    = 5'd10;
  localparam logic [4:0] S_M1    = 5'd11;
  localparam logic [4:0] S_M2    = 5'd12;
  localparam logic [4:0] S_TIME  = 5'd13;
  localparam logic [4:0] S_SRCH  = 5'd14;
  localparam logic [4:0] S_NEXT  = 5'd15;
  localparam logic [4:0] S_SHIFT = 5'd16;
  localparam logic [4:0] S_QGO   = 5'd17;
  localparam logic [4:0] S_QWAIT = 5'd18;
  localparam logic [4:0] S_QLAT  = 5'd19;
  localparam logic [4:0] S_NEWF  = 5'd22;
  localparam logic [4:0] S_MASS  = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.rd_sel  = RD_ZERO;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && req_type_i) begin
          state_d = S_T0;
        end
      end
      S_T0: state_d = S_CHK;
      S_CHK: begin
        cmd_o.op = OP_CHECK;
        if (stat_i.invalid) begin
          state_d = S_OUT;
        end else if (stat_i.direct) begin
          state_d = S_SEG;
        end else begin
          state_d = S_RGO;
        end
      end
      S_RGO: begin
        cmd_o.op = OP_DIV_RATIO;
        state_d  = S_RWAIT;
      end
      S_RWAIT: if (stat_i.div_done) begin
        state_d = S_RCMP;
      end
      S_RCMP: begin
        cmd_o.op = OP_RCMP;
        state_d  = stat_i.ratio_big ? S_EMUL : S_OUT;
      end
      S_EMUL: begin
        cmd_o.op = OP_EMUL;
        state_d  = S_EFF;
      end
      S_EFF: begin
        cmd_o.op = OP_EFF;
        state_d  = S_SEG;
      end
      S_SEG: begin
        cmd_o.op = OP_SEG;
        state_d  = stat_i.seg_past ? S_MASS : S_RLO;
      end
      S_RLO: begin
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_LO;
      end
      S_LO: begin
        cmd_o.op     = OP_LATCH_LO;
        cmd_o.rd_sel = RD_IDX1;
        state_d      = S_M1;
      end
      S_M1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_TIME;
      end
      S_TIME: begin
        cmd_o.op = OP_TIME;
        state_d  = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.op = OP_SEARCH;
        if (stat_i.hit) begin
          state_d = stat_i.flat ? S_NEWF : S_QGO;
        end else begin
          state_d = stat_i.last_seg ? S_MASS : S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.rd_sel = RD_IDX1;
        state_d      = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d  = S_SRCH;
      end
      S_QGO: begin
        cmd_o.op = OP_DIV_Q;
        state_d  = S_QWAIT;
      end
      S_QWAIT: if (stat_i.div_done) begin
        state_d = S_QLAT;
      end
      S_QLAT: begin
        cmd_o.op = OP_QLAT;
        state_d  = S_NEWF;
      end
      S_NEWF: begin
        cmd_o.op = OP_NEWF;
        state_d  = S_MASS;
      end
      S_MASS: begin
        cmd_o.op = OP_MASS;
        state_d  = S_OUT;
      end
      S_OUT: if (out_ready_i) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;

endmodule
